// ===== hdl/wlsa_pkg.sv =====
// Shared types and constants for the wear leveling sector allocator.
// Used by wlsa_table and wear_leveling_sector_allocator_top; no dependencies.
package wlsa_pkg;

    localparam int SW = 8;
    localparam logic [SW-1:0] NONE = 8'hFF;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_ERASE = 2'd2,
        OP_ROOT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ERS_RD,
        ST_ERS_WR,
        ST_SCAN,
        ST_ALC_WR,
        ST_AFT_RD,
        ST_AFT_WR,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [SW-1:0] owner;
        logic [SW-1:0] link;
        logic [SW-1:0] wear;
    } entry_t;

    localparam entry_t ENTRY_NONE = '{owner: NONE, link: NONE, wear: NONE};

    typedef struct packed {
        logic          en;
        logic [SW-1:0] addr;
        entry_t        data;
    } tbl_wr_t;

endpackage

// ===== hdl/wlsa_table.sv =====
// Sector entry memory: owner, link and wear counter per sector, one write
// and one registered read port. Per-entry valid bits make unwritten entries
// read as all 255. Depends on wlsa_pkg.
module wlsa_table import wlsa_pkg::*; #(
    parameter int SECTORS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  tbl_wr_t       wr,
    input  logic [SW-1:0] rd_addr,
    output entry_t        rd_entry
);

    localparam int AW = $clog2(SECTORS);

    entry_t               mem [SECTORS];
    logic [SECTORS-1:0]   vld_reg;
    entry_t               rd_data_reg;
    logic                 rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            rd_hit_reg <= vld_reg[rd_addr[AW-1:0]];
            if (wr.en) begin
                vld_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
        end
    end

    assign rd_entry = rd_hit_reg ? rd_data_reg : ENTRY_NONE;

endmodule

// ===== hdl/wear_leveling_sector_allocator_top.sv =====
// Wear leveling sector allocator, one word in, one word out.
// Load writes its entry; erase reads the entry, then writes it back; an out-of-range load or
// erase answers at once. Allocate and find-root each scan the table once through the single
// read port; a find-root whose file is present then walks the parent list step by step.
// Throughput: one word at a time; the next word is taken the cycle after the result registers.
// Reset (aresetn low, synchronous) marks every table entry as all 255.
module wear_leveling_sector_allocator_top import wlsa_pkg::*; #(
    parameter int SECTORS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] sector, [15:8] file_id, [23:16] next_sector, [31:24] erase_count,
    // [39:32] chain_after
    input  logic [39:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] result_sector, [9:8] status, [15:10] zero
    output logic [15:0] m_tdata
);

    localparam int AW = $clog2(SECTORS);
    localparam int CW = $clog2(SECTORS + 1);
    localparam logic [SW-1:0] SEC8 = SW'(SECTORS);
    localparam logic [CW-1:0] SECC = CW'(SECTORS);

    state_t         state_reg, state_next;

    op_t            op_reg;
    logic [SW-1:0]  sec_reg, fid_reg, nxt_reg, cnt_in_reg, after_reg;
    logic [SW-1:0]  res_reg, low_reg;
    status_t        status_reg;
    logic [CW-1:0]  cnt_reg;
    logic           eval_vld_reg;
    logic [AW-1:0]  eval_idx_reg;
    logic           never_found_reg;
    logic [AW-1:0]  never_idx_reg;

    logic [SW-1:0]  m_result_reg;
    status_t        m_status_reg;
    logic           m_tvalid_reg;

    logic [AW-1:0]      par_mem [SECTORS];
    logic [SECTORS-1:0] par_vld_reg;
    logic [AW-1:0]      par_rd_reg;
    logic               par_hit_reg;
    logic               par_we;

    tbl_wr_t        tbl_wr;
    logic [SW-1:0]  tbl_rd_addr;
    entry_t         ent;

    logic           accept;
    op_t            s_op;
    logic [SW-1:0]  s_sec;
    logic           scan_done;
    logic           after_ok;

    assign accept    = s_tvalid && s_tready;
    assign s_op      = op_t'(s_tuser);
    assign s_sec     = s_tdata[7:0];
    assign scan_done = (cnt_reg == SECC) && !eval_vld_reg;
    assign after_ok  = (after_reg != NONE) && (after_reg < SEC8);

    wlsa_table #(
        .SECTORS (SECTORS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (tbl_wr),
        .rd_addr  (tbl_rd_addr),
        .rd_entry (ent)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        OP_LOAD:  state_next = (s_sec < SEC8) ? ST_LOAD : ST_RESP;
                        OP_ERASE: state_next = (s_sec < SEC8) ? ST_ERS_RD : ST_RESP;
                        OP_ALLOC: state_next = ST_SCAN;
                        OP_ROOT:  state_next = ST_SCAN;
                        default:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_LOAD:   state_next = ST_RESP;
            ST_ERS_RD: state_next = ST_ERS_WR;
            ST_ERS_WR: state_next = ST_RESP;
            ST_SCAN: begin
                if (scan_done) begin
                    if (op_reg == OP_ALLOC) begin
                        state_next = (never_found_reg || res_reg != NONE) ? ST_ALC_WR
                                                                          : ST_RESP;
                    end else begin
                        state_next = (res_reg != NONE) ? ST_WALK_RD : ST_RESP;
                    end
                end
            end
            ST_ALC_WR:   state_next = after_ok ? ST_AFT_RD : ST_RESP;
            ST_AFT_RD:   state_next = ST_AFT_WR;
            ST_AFT_WR:   state_next = ST_RESP;
            ST_WALK_RD:  state_next = ST_WALK_CHK;
            ST_WALK_CHK: begin
                state_next = (par_hit_reg && (cnt_reg + CW'(1)) != SECC) ? ST_WALK_RD
                                                                         : ST_RESP;
            end
            ST_RESP:     state_next = (!m_tvalid_reg || m_tready) ? ST_IDLE : ST_RESP;
            default:     state_next = ST_IDLE;
        endcase
    end

    // table port and handshake outputs
    always_comb begin
        tbl_wr      = '0;
        tbl_rd_addr = SW'(cnt_reg[AW-1:0]);
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_LOAD: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = sec_reg;
                tbl_wr.data = '{owner: fid_reg, link: nxt_reg, wear: cnt_in_reg};
            end
            ST_ERS_RD: tbl_rd_addr = sec_reg;
            ST_ERS_WR: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = sec_reg;
                tbl_wr.data = '{owner: NONE, link: NONE, wear: ent.wear + SW'(1)};
            end
            ST_ALC_WR: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = res_reg;
                tbl_wr.data = '{owner: fid_reg, link: NONE, wear: low_reg};
            end
            ST_AFT_RD: tbl_rd_addr = after_reg;
            ST_AFT_WR: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = after_reg;
                tbl_wr.data = '{owner: ent.owner, link: res_reg, wear: ent.wear};
            end
            default: ;
        endcase
    end

    assign par_we = (state_reg == ST_SCAN) && eval_vld_reg && (op_reg == OP_ROOT)
                    && (ent.owner == fid_reg) && (ent.link < SEC8);

    // parent list memory
    always_ff @(posedge aclk) begin
        if (par_we) begin
            par_mem[ent.link[AW-1:0]] <= eval_idx_reg;
        end
        par_rd_reg <= par_mem[res_reg[AW-1:0]];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            eval_vld_reg    <= 1'b0;
            never_found_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            par_vld_reg     <= '0;
            par_hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            par_hit_reg <= par_vld_reg[res_reg[AW-1:0]];
            // raise on a fresh result, drop once the held one is taken
            if (state_reg == ST_RESP && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cnt_reg         <= '0;
                        eval_vld_reg    <= 1'b0;
                        never_found_reg <= 1'b0;
                        par_vld_reg     <= '0;
                    end
                end
                ST_SCAN: begin
                    eval_vld_reg <= (cnt_reg < SECC);
                    if (cnt_reg < SECC) begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (scan_done) begin
                        cnt_reg <= '0;
                    end
                    if (eval_vld_reg && op_reg == OP_ALLOC && ent.owner == NONE
                        && ent.wear == NONE && !never_found_reg) begin
                        never_found_reg <= 1'b1;
                    end
                    if (par_we) begin
                        par_vld_reg[ent.link[AW-1:0]] <= 1'b1;
                    end
                end
                ST_WALK_CHK: cnt_reg <= cnt_reg + CW'(1);
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_reg     <= s_op;
                    sec_reg    <= s_sec;
                    fid_reg    <= s_tdata[15:8];
                    nxt_reg    <= s_tdata[23:16];
                    cnt_in_reg <= s_tdata[31:24];
                    after_reg  <= s_tdata[39:32];
                    status_reg <= STAT_OK;
                    low_reg    <= NONE;
                    if ((s_op == OP_LOAD || s_op == OP_ERASE) && s_sec < SEC8) begin
                        res_reg <= s_sec;
                    end else begin
                        res_reg <= NONE;
                    end
                end
            end
            ST_SCAN: begin
                eval_idx_reg <= cnt_reg[AW-1:0];
                if (eval_vld_reg) begin
                    if (op_reg == OP_ALLOC) begin
                        if (ent.owner == NONE) begin
                            if (ent.wear == NONE) begin
                                if (!never_found_reg) begin
                                    never_idx_reg <= eval_idx_reg;
                                end
                            end else if (ent.wear < low_reg) begin
                                low_reg <= ent.wear;
                                res_reg <= SW'(eval_idx_reg);
                            end
                        end
                    end else if (ent.owner == fid_reg && res_reg == NONE) begin
                        res_reg <= SW'(eval_idx_reg);
                    end
                end
                if (scan_done) begin
                    if (op_reg == OP_ALLOC) begin
                        if (never_found_reg) begin
                            res_reg <= SW'(never_idx_reg);
                            low_reg <= NONE;
                        end else if (res_reg == NONE) begin
                            status_reg <= STAT_NO_FREE;
                        end
                    end else if (res_reg == NONE) begin
                        status_reg <= STAT_NOT_FOUND;
                    end
                end
            end
            ST_WALK_CHK: begin
                if (par_hit_reg) begin
                    res_reg <= SW'(par_rd_reg);
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_result_reg <= res_reg;
                    m_status_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_status_reg, m_result_reg};

    // the walk only ever follows real sectors
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK_RD) |-> (res_reg < SEC8))
        else $error("parent walk left the sector range");

    // table writes stay inside the table
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.en |-> (tbl_wr.addr < SEC8))
        else $error("table write beyond last sector");

    // failures carry no sector
    a_fail_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg != STAT_OK) |-> (m_result_reg == NONE))
        else $error("failed result carries a sector");

    // once a word is taken, a scan begins with its count cleared
    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_SCAN || cnt_reg == '0))
        else $error("scan started with stale count");

endmodule
